// ===== src/sdr_pkg.sv =====
package sdr_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned HALF_W    = 32;
    // one quotient bit per divide stage
    localparam int unsigned DIV_STEPS = DATA_W;
    // operand stage + divide stages + result stage
    localparam int unsigned LATENCY   = DIV_STEPS + 2;

    localparam logic [1:0] CMD_QUO32 = 2'd0;
    localparam logic [1:0] CMD_REM32 = 2'd1;
    localparam logic [1:0] CMD_QUO64 = 2'd2;
    localparam logic [1:0] CMD_REM64 = 2'd3;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] dividend;
        logic signed [DATA_W-1:0] divisor;
    } sdr_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] answer;
        logic                     divide_by_zero;
    } sdr_out_t;

    // state carried down the divide pipeline
    typedef struct packed {
        logic              valid;
        logic              wide;
        logic              want_rem;
        logic              neg_quo;
        logic              neg_rem;
        logic              div_zero;
        logic [DATA_W-1:0] rem;      // partial remainder
        logic [DATA_W-1:0] quo;      // dividend bits shift out, quotient bits shift in
        logic [DATA_W-1:0] mag_div;  // divisor magnitude
    } sdr_stage_t;

endpackage

// ===== src/sdr_prep.sv =====
module sdr_prep
    import sdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  sdr_in_t    operands,
    output sdr_stage_t stage_out
);

    logic              wide;
    logic              want_rem;
    logic [DATA_W-1:0] a_ext;
    logic [DATA_W-1:0] b_ext;
    sdr_stage_t        data_next;
    sdr_stage_t        data_reg;
    logic              valid_reg;

    always_comb
    begin
        wide     = (operands.command == CMD_QUO64) || (operands.command == CMD_REM64);
        want_rem = (operands.command == CMD_REM32) || (operands.command == CMD_REM64);
        // 32-bit modes: sign-extend the low halves, magnitudes then match
        if (wide)
        begin
            a_ext = operands.dividend;
            b_ext = operands.divisor;
        end
        else
        begin
            a_ext = {{HALF_W{operands.dividend[HALF_W-1]}}, operands.dividend[HALF_W-1:0]};
            b_ext = {{HALF_W{operands.divisor[HALF_W-1]}}, operands.divisor[HALF_W-1:0]};
        end

        data_next          = '0;
        data_next.wide     = wide;
        data_next.want_rem = want_rem;
        data_next.neg_quo  = a_ext[DATA_W-1] ^ b_ext[DATA_W-1];
        data_next.neg_rem  = a_ext[DATA_W-1];
        data_next.div_zero = (b_ext == '0);
        data_next.rem      = '0;
        data_next.quo      = a_ext[DATA_W-1] ? (~a_ext + 1'b1) : a_ext;
        data_next.mag_div  = b_ext[DATA_W-1] ? (~b_ext + 1'b1) : b_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// ===== src/sdr_div_stage.sv =====
module sdr_div_stage
    import sdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sdr_stage_t stage_in,
    output sdr_stage_t stage_out
);

    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;
    logic            fits;
    sdr_stage_t      data_next;
    sdr_stage_t      data_reg;
    logic            valid_reg;

    // restoring step: partial remainder stays below the divisor, so
    // the shifted value fits in DATA_W bits
    always_comb
    begin
        shifted        = {stage_in.rem, stage_in.quo[DATA_W-1]};
        diff           = shifted - {1'b0, stage_in.mag_div};
        fits           = !diff[DATA_W];
        data_next      = stage_in;
        data_next.rem  = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        data_next.quo  = {stage_in.quo[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// ===== src/sdr_post.sv =====
module sdr_post
    import sdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sdr_stage_t stage_in,
    output sdr_out_t   result,
    output logic       done
);

    logic [DATA_W-1:0] raw;
    logic              neg;
    logic [DATA_W-1:0] signed_val;
    sdr_out_t          result_next;
    sdr_out_t          result_reg;
    logic              done_reg;

    always_comb
    begin
        raw        = stage_in.want_rem ? stage_in.rem : stage_in.quo;
        neg        = stage_in.want_rem ? stage_in.neg_rem : stage_in.neg_quo;
        signed_val = neg ? (~raw + 1'b1) : raw;

        result_next.divide_by_zero = stage_in.div_zero;
        if (stage_in.div_zero)
        begin
            result_next.answer = '0;
        end
        else if (stage_in.wide)
        begin
            result_next.answer = signed_val;
        end
        else
        begin
            result_next.answer = {{HALF_W{signed_val[HALF_W-1]}}, signed_val[HALF_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== src/signed_divide_remainder_core.sv =====
// Signed 32/64-bit divide and remainder, fully pipelined. A command beat
// is taken whenever start is high; busy is always low, so one command can
// enter every clock. Each result appears on result for exactly one cycle
// with done high, once its start beat has passed through every stage:
// one operand stage, 64 restoring divide stages (one quotient bit
// each, one 65-bit subtract per stage) and one sign/result stage. Results
// leave in command order and cannot be held off, so capture them when
// done is high. Quotients truncate toward zero, remainders take the sign
// of the dividend, the most negative value over minus one wraps to itself,
// and a zero divisor returns zero with divide_by_zero set. 32-bit commands
// use only the low operand halves and sign-extend the answer.
module signed_divide_remainder_core
    import sdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sdr_in_t  operands,
    output sdr_out_t result,
    output logic     done
);

    logic       accept;
    // chain[0] is the operand stage, chain[k] the k-th divide stage
    sdr_stage_t chain [0:DIV_STEPS];

    // no stalls anywhere: the pipeline always advances
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // magnitudes, signs and zero-divisor check
    sdr_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operands  (operands),
        .stage_out (chain[0])
    );

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        sdr_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[k]),
            .stage_out (chain[k+1])
        );
    end

    // pick quotient or remainder, apply sign, fold 32-bit modes
    sdr_post u_post
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (chain[DIV_STEPS]),
        .result   (result),
        .done     (done)
    );

    // every accepted beat produces its result a fixed latency later
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted beat did not complete after LATENCY cycles");

    // no result without a matching accepted beat
    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without an accepted beat");

    // zero divisor always returns zero
    a_zero_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |-> (result.answer == '0))
        else $error("divide by zero returned a nonzero answer");

endmodule

// ===== bench/testbench.sv =====
module testbench
    import sdr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Bench for the pipelined signed divide/remainder core. Command beats go
    // in through start/busy, results come back one cycle each on done and
    // cannot be held off, so every result is checked in the cycle it shows.
    // Expected answers come from typed table entries or from an independent model of the divide below.

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int RANDOM_BEATS   = 1078;
    localparam int MAX_GAP        = 20;
    // nothing moves for this long: hung. Covers the pipeline fill (LATENCY)
    // plus the longest sender gap many times over.
    localparam int WATCHDOG_LIMIT = 20 * (LATENCY + MAX_GAP);
    localparam int PRINT_CAP      = 50;

    typedef struct {
        sdr_in_t  beat;
        bit       known;   // answer typed into the table
        sdr_out_t want;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    sdr_in_t  operands;
    sdr_out_t result;
    logic     done;

    // travel alongside operands: typed expectation for a directed row
    bit       beat_known;
    sdr_out_t known_answer;

    sdr_out_t  answers_due[$];
    stim_row_t stim_table[$];
    int        fail_count = 0;
    int        results_seen = 0;
    int        stall_cycles = 0;

    signed_divide_remainder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .result   (result),
        .done     (done)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Independent divide model. 32-bit commands sign-extend the low halves
    // first, so a single 64-bit magnitude divide serves both widths; the
    // wrap of most-negative over minus one falls out of the negation.
    function automatic sdr_out_t signed_divide_answer(sdr_in_t beat);
        logic     wide;
        logic     want_rem;
        logic     neg_a;
        logic     neg_b;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] r;
        sdr_out_t res;
        wide     = (beat.command == CMD_QUO64) || (beat.command == CMD_REM64);
        want_rem = (beat.command == CMD_REM32) || (beat.command == CMD_REM64);
        a = beat.dividend;
        b = beat.divisor;
        if (!wide)
        begin
            a = {{32{a[31]}}, a[31:0]};
            b = {{32{b[31]}}, b[31:0]};
        end
        if (b == 64'd0)
        begin
            res.answer         = '0;
            res.divide_by_zero = 1'b1;
            return res;
        end
        neg_a = a[63];
        neg_b = b[63];
        mag_a = neg_a ? -a : a;
        mag_b = neg_b ? -b : b;
        if (want_rem)
        begin
            r = mag_a % mag_b;
            if (neg_a)
                r = -r;
        end
        else
        begin
            r = mag_a / mag_b;
            if (neg_a != neg_b)
                r = -r;
        end
        if (!wide)
            r = {{32{r[31]}}, r[31:0]};
        res.answer         = r;
        res.divide_by_zero = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t ns: result %0d %s: got %h, want %h",
                     $time, results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic add_row(input logic [1:0] command, input logic [63:0] dividend,
                           input logic [63:0] divisor, input bit known,
                           input logic [63:0] answer, input logic dbz);
        stim_row_t row;
        row.beat.command        = command;
        row.beat.dividend       = dividend;
        row.beat.divisor        = divisor;
        row.known               = known;
        row.want.answer         = answer;
        row.want.divide_by_zero = dbz;
        stim_table.push_back(row);
    endtask

    // Operand shapes: plain random, small values, varied magnitudes, edge
    // values, and words whose low half is zero (narrow zero divisor).
    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        case ($urandom_range(9))
            4:
            begin
                v = 64'($urandom_range(100));
                if ($urandom_range(1))
                    v = -v;
            end
            5:
            begin
                v = {$urandom, $urandom} >> $urandom_range(63);
                if ($urandom_range(1))
                    v = -v;
            end
            6:
            begin
                case ($urandom_range(7))
                    0: v = MIN64;
                    1: v = MAX64;
                    2: v = ONES;
                    3: v = 64'd0;
                    4: v = 64'd1;
                    5: v = {$urandom, 32'h8000_0000};
                    6: v = {$urandom, 32'hFFFF_FFFF};
                    default: v = {$urandom, 32'h7FFF_FFFF};
                endcase
            end
            7: v = {$urandom, 32'h0};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // One command beat. Optional idle gap first (start low), then hold the
    // beat until an edge sees start high with busy low. Returns in the step
    // of that edge, so the next call makes the only assignment to start.
    task automatic send_beat(input sdr_in_t beat, input bit known,
                             input sdr_out_t want, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        operands     <= beat;
        beat_known   <= known;
        known_answer <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Scoreboard: log expectations at accepted beats, check each done beat
    // against the oldest one. Values read here are the pre-edge ones.
    always @(posedge clk)
    begin : scoreboard
        sdr_out_t want;
        if (rst_n)
        begin
            if (start && !busy)
                answers_due.push_back(beat_known ? known_answer
                                                 : signed_divide_answer(operands));
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch("with nothing outstanding", result.answer, '0);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (result.answer !== want.answer)
                        report_mismatch("answer", result.answer, want.answer);
                    if (result.divide_by_zero !== want.divide_by_zero)
                        report_mismatch("divide_by_zero", 64'(result.divide_by_zero),
                                        64'(want.divide_by_zero));
                end
                results_seen++;
            end
        end
    end

    // Watchdog on cycles with no beat in or out.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        sdr_in_t  beat;
        sdr_out_t none;
        int       idle_pct[4];
        int       per_phase;

        rst_n        = 1'b0;
        start        = 1'b0;
        operands     = '0;
        beat_known   = 1'b0;
        known_answer = '0;
        none         = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed answers only for zero divisors, edge values
        // and the narrow upper-half row; the rest go through the model.
        add_row(CMD_QUO32, 64'd7, 64'd2, 0, '0, 1'b0);
        add_row(CMD_REM32, -64'd7, 64'd2, 0, '0, 1'b0);
        add_row(CMD_QUO64, -64'd7, 64'd2, 0, '0, 1'b0);
        add_row(CMD_REM64, 64'd7, -64'd2, 0, '0, 1'b0);
        // zero divisor, every command
        add_row(CMD_QUO32, MAX64, 64'd0, 1, '0, 1'b1);
        add_row(CMD_REM32, MIN64, 64'd0, 1, '0, 1'b1);
        add_row(CMD_QUO64, ONES, 64'd0, 1, '0, 1'b1);
        add_row(CMD_REM64, 64'd5, 64'd0, 1, '0, 1'b1);
        // narrow mode sees only the low half: zero there is still zero
        add_row(CMD_QUO32, 64'd100, 64'hDEAD_BEEF_0000_0000, 1, '0, 1'b1);
        add_row(CMD_REM32, ONES, 64'hFFFF_FFFF_0000_0000, 1, '0, 1'b1);
        add_row(CMD_QUO64, 64'd100, 64'hDEAD_BEEF_0000_0000, 0, '0, 1'b0);
        // most negative over minus one wraps; remainder is zero
        add_row(CMD_QUO32, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF,
                1, 64'hFFFF_FFFF_8000_0000, 1'b0);
        add_row(CMD_REM32, 64'h0000_0000_8000_0000, ONES, 1, '0, 1'b0);
        add_row(CMD_QUO64, MIN64, ONES, 1, MIN64, 1'b0);
        add_row(CMD_REM64, MIN64, ONES, 1, '0, 1'b0);
        add_row(CMD_QUO64, MAX64, 64'd1, 1, MAX64, 1'b0);
        add_row(CMD_QUO64, MIN64, MIN64, 1, 64'd1, 1'b0);
        add_row(CMD_REM64, MAX64, MIN64, 1, MAX64, 1'b0);
        add_row(CMD_REM64, MIN64, MAX64, 0, '0, 1'b0);
        // upper halves ignored in narrow mode: -7 / 2 = -3
        add_row(CMD_QUO32, 64'h1234_5678_FFFF_FFF9, 64'hABCD_0000_0000_0002,
                1, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0);
        add_row(CMD_REM32, 64'hFFFF_FFFF_7FFF_FFFF, 64'h0000_0000_0000_0010, 0, '0, 1'b0);
        add_row(CMD_QUO32, ONES, ONES, 0, '0, 1'b0);
        add_row(CMD_REM64, 64'd0, 64'd5, 0, '0, 1'b0);
        add_row(CMD_QUO64, 64'd1, MIN64, 0, '0, 1'b0);

        foreach (stim_table[i])
            send_beat(stim_table[i].beat, stim_table[i].known, stim_table[i].want, 0);

        // Random part in phases of sender idling. The receiver cannot stall,
        // so its phase runs back to back like the first.
        idle_pct  = '{0, 57, 0, 36};
        per_phase = RANDOM_BEATS / 4;
        foreach (idle_pct[p])
        begin
            repeat (per_phase)
            begin
                beat.command  = 2'($urandom_range(3));
                beat.dividend = random_operand();
                beat.divisor  = random_operand();
                send_beat(beat, 1'b0, none, idle_pct[p]);
            end
        end
        start <= 1'b0;
        @(posedge clk);

        // drain, then a pipeline's worth more to catch stray done beats
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== signed_divide_remainder_core.f =====
src/sdr_pkg.sv
src/sdr_prep.sv
src/sdr_div_stage.sv
src/sdr_post.sv
src/signed_divide_remainder_core.sv
bench/testbench.sv
